// ===== rtl/cvf_pkg.sv =====
// ----------------------------------------------------------------------------
// cvf_pkg
// Shared types, constants and the slope table for the channel volume fader.
// ----------------------------------------------------------------------------
package cvf_pkg;

    localparam int CHANNELS  = 16;
    localparam int FADE_MS   = 16;
    localparam int FRAC_BITS = 12;

    // Active channel count, capped by the 4-bit channel field.
    localparam int NCH    = (CHANNELS < 16) ? CHANNELS : 16;
    localparam int ADDR_W = (NCH > 1) ? $clog2(NCH) : 1;

    localparam int LEVEL_W = 7;
    localparam int LEFT_W  = 8;
    localparam int ELAP_W  = 16;

    // Largest slope magnitude is 127 * 4096 / FADE_MS.
    localparam int SLOPE_MAX = (127 * (1 << FRAC_BITS)) / FADE_MS;
    localparam int SLOPE_W   = $clog2(SLOPE_MAX + 1);
    localparam int PROD_W    = SLOPE_W + LEFT_W;
    localparam int LINE_W    = PROD_W + 2;

    typedef enum logic [1:0] {
        ACT_NOTE_ON    = 2'd0,
        ACT_START_FADE = 2'd1,
        ACT_TICK       = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CRD  = 7'b0000010,
        ST_CWR  = 7'b0000100,
        ST_RD   = 7'b0001000,
        ST_LOOK = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_WB   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic               fade_on;
        logic [LEFT_W-1:0]  left_ms;
        logic [LEVEL_W-1:0] base;
        logic [LEVEL_W-1:0] goal;
        logic [LEVEL_W-1:0] faded;
        logic               mute;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);

    localparam chan_entry_t RESET_ENTRY = '{
        fade_on: 1'b0,
        left_ms: '0,
        base:    '0,
        goal:    '0,
        faded:   7'd127,
        mute:    1'b0
    };

    typedef logic [SLOPE_W-1:0] slope_tab_t [128];

    // Slope magnitude per volume difference: |diff| * 4096 / FADE_MS, truncated.
    function automatic slope_tab_t build_slope_tab();
        slope_tab_t t;
        for (int i = 0; i < 128; i++)
        begin
            t[i] = SLOPE_W'((i * (1 << FRAC_BITS)) / FADE_MS);
        end
        return t;
    endfunction

    localparam slope_tab_t SLOPE_TAB = build_slope_tab();

endpackage

// ===== rtl/channel_volume_fader.sv =====
// ----------------------------------------------------------------------------
// channel_volume_fader
// Multi-channel linear volume fader: per-channel state in one RAM, a tick
// sweeps all channels and reports one transfer per channel.
// ----------------------------------------------------------------------------
// Sequence: note_on / start_fade step through accept, read and write back.
// A tick has an accept step, then for each channel a read, table lookup,
// multiply and write-back step; write back holds while the output is stalled.
// Each report is loaded into the output register by a channel's write back.
// One item is in work at a time; the four-step channel sweep sets the pace.
// Reset: rst_n clears the sequencer, output valid and the per-entry valid
// bits; an entry never written reads as its reset value, so no clearing pass.
// ----------------------------------------------------------------------------
module channel_volume_fader
    import cvf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [3:0]          channel,
    input  logic [LEVEL_W-1:0]  level,
    input  logic [ELAP_W-1:0]   elapsed_ms,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          chan_index,
    output logic [LEVEL_W-1:0]  fader_level,
    output logic                fading,
    output logic                silenced,
    output logic                last
);

    // ------------------------------------------------------------------
    // Sequencer and latched command
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    action_t             cmd_act_reg, cmd_act_next;
    logic [ADDR_W-1:0]   cmd_ch_reg, cmd_ch_next;
    logic [LEVEL_W-1:0]  cmd_level_reg, cmd_level_next;
    logic [ELAP_W-1:0]   elapsed_reg, elapsed_next;

    // Tick datapath stages
    chan_entry_t         ent_reg, ent_next;
    logic [SLOPE_W-1:0]  slope_mag_reg, slope_mag_next;
    logic                slope_neg_reg, slope_neg_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Per-entry valid bits; an invalid entry reads as RESET_ENTRY.
    logic [NCH-1:0]      valid_reg, valid_next;
    logic                rd_vld_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          chan_index_reg, chan_index_next;
    logic [LEVEL_W-1:0]  fader_level_reg, fader_level_next;
    logic                fading_reg, fading_next;
    logic                silenced_reg, silenced_next;
    logic                last_reg, last_next;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    chan_entry_t         ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Combinational helpers
    logic                in_xfer;
    logic                out_free;
    logic                ch_ok;
    logic                cnt_last;
    chan_entry_t         rd_ent;
    chan_entry_t         cmd_ent;
    chan_entry_t         wb_ent;
    logic [LEFT_W-1:0]   left_new;
    logic [LEVEL_W-1:0]  diff_mag;
    logic                diff_neg;
    logic signed [LINE_W-1:0] goal_term;
    logic signed [LINE_W-1:0] prod_term;
    logic signed [LINE_W-1:0] line_val;
    logic [LEVEL_W-1:0]  line_lvl;

    cvf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NCH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Accept only when idle; a finished result may still sit in the output.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign ch_ok    = ({1'b0, channel} < 5'(NCH));
    assign cnt_last = (cnt_reg == ADDR_W'(NCH - 1));

    // Read address: the command's channel, else the sweep counter.
    assign ram_raddr = (state_reg == ST_CRD) ? cmd_ch_reg : cnt_reg;
    assign rd_ent    = rd_vld_reg ? chan_entry_t'(ram_rdata) : RESET_ENTRY;

    // ------------------------------------------------------------------
    // Tick arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        // Remaining time counts down, saturating at zero.
        if ({{(ELAP_W - LEFT_W){1'b0}}, rd_ent.left_ms} > elapsed_reg)
        begin
            left_new = rd_ent.left_ms - elapsed_reg[LEFT_W-1:0];
        end
        else
        begin
            left_new = '0;
        end

        // Slope sign and magnitude; slope = (base - goal) * 4096 / FADE_MS.
        diff_neg = (rd_ent.base < rd_ent.goal);
        diff_mag = diff_neg ? (rd_ent.goal - rd_ent.base) : (rd_ent.base - rd_ent.goal);

        // goal * 4096 +/- |slope| * left, then clamp to 0..127.
        goal_term = $signed({{(LINE_W - LEVEL_W - FRAC_BITS){1'b0}}, ent_reg.goal,
                             {FRAC_BITS{1'b0}}});
        prod_term = $signed({2'b00, prod_reg});
        line_val  = slope_neg_reg ? (goal_term - prod_term) : (goal_term + prod_term);

        priority if (line_val[LINE_W-1])
        begin
            line_lvl = '0;
        end
        else if (|line_val[LINE_W-2:FRAC_BITS+LEVEL_W])
        begin
            line_lvl = 7'd127;
        end
        else
        begin
            line_lvl = line_val[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
        end

        // Write-back entry for the channel under the sweep.
        wb_ent = ent_reg;
        if (ent_reg.fade_on)
        begin
            if (ent_reg.left_ms == '0)
            begin
                wb_ent.fade_on = 1'b0;
                wb_ent.base    = ent_reg.goal;
                wb_ent.faded   = ent_reg.goal;
                wb_ent.mute    = ent_reg.mute || (ent_reg.goal == '0);
            end
            else
            begin
                wb_ent.faded = line_lvl;
            end
        end
    end

    // Command modify: note_on sets the volume, start_fade arms a fade.
    always_comb
    begin
        cmd_ent = rd_ent;
        unique case (cmd_act_reg)
            ACT_NOTE_ON:
            begin
                cmd_ent.base    = cmd_level_reg;
                cmd_ent.faded   = cmd_level_reg;
                cmd_ent.fade_on = 1'b0;
                cmd_ent.left_ms = '0;
                cmd_ent.mute    = 1'b0;
            end
            ACT_START_FADE:
            begin
                cmd_ent.fade_on = 1'b1;
                cmd_ent.left_ms = LEFT_W'(FADE_MS);
                cmd_ent.goal    = cmd_level_reg;
            end
            default:
            begin
                cmd_ent = rd_ent;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmd_act_next     = cmd_act_reg;
        cmd_ch_next      = cmd_ch_reg;
        cmd_level_next   = cmd_level_reg;
        elapsed_next     = elapsed_reg;
        ent_next         = ent_reg;
        slope_mag_next   = slope_mag_reg;
        slope_neg_next   = slope_neg_reg;
        prod_next        = prod_reg;
        valid_next       = valid_reg;

        // Drop the output once the consumer takes it.
        out_valid_next   = out_valid_reg && out_stall;
        chan_index_next  = chan_index_reg;
        fader_level_next = fader_level_reg;
        fading_next      = fading_reg;
        silenced_next    = silenced_reg;
        last_next        = last_reg;

        ram_we           = 1'b0;
        ram_waddr        = cnt_reg;
        ram_wdata        = wb_ent;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_act_next   = action_t'(action);
                    cmd_ch_next    = channel[ADDR_W-1:0];
                    cmd_level_next = level;
                    elapsed_next   = elapsed_ms;
                    cnt_next       = '0;
                    priority if (action == ACT_TICK)
                    begin
                        state_next = ST_RD;
                    end
                    else if ((action == ACT_NOTE_ON || action == ACT_START_FADE) && ch_ok)
                    begin
                        state_next = ST_CRD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CRD:
            begin
                state_next = ST_CWR;
            end
            ST_CWR:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = cmd_ch_reg;
                ram_wdata              = cmd_ent;
                valid_next[cmd_ch_reg] = 1'b1;
                state_next             = ST_IDLE;
            end
            ST_RD:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                ent_next = rd_ent;
                if (rd_ent.fade_on)
                begin
                    ent_next.left_ms = left_new;
                end
                slope_mag_next = SLOPE_TAB[diff_mag];
                slope_neg_next = diff_neg;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(slope_mag_reg) * PROD_W'(ent_reg.left_ms);
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // Hold until the output register can take the result.
                if (out_free)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = cnt_reg;
                    ram_wdata           = wb_ent;
                    valid_next[cnt_reg] = 1'b1;
                    out_valid_next      = 1'b1;
                    chan_index_next     = 4'(cnt_reg);
                    fader_level_next    = wb_ent.faded;
                    fading_next         = wb_ent.fade_on;
                    silenced_next       = wb_ent.mute;
                    last_next           = cnt_last;
                    if (cnt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_act_reg     <= cmd_act_next;
        cmd_ch_reg      <= cmd_ch_next;
        cmd_level_reg   <= cmd_level_next;
        elapsed_reg     <= elapsed_next;
        ent_reg         <= ent_next;
        slope_mag_reg   <= slope_mag_next;
        slope_neg_reg   <= slope_neg_next;
        prod_reg        <= prod_next;
        chan_index_reg  <= chan_index_next;
        fader_level_reg <= fader_level_next;
        fading_reg      <= fading_next;
        silenced_reg    <= silenced_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign chan_index  = chan_index_reg;
    assign fader_level = fader_level_reg;
    assign fading      = fading_reg;
    assign silenced    = silenced_reg;
    assign last        = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The last flag marks exactly the final active channel.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (chan_index == 4'(NCH - 1))))
        else $error("last flag does not match final channel");

    // A new result is only loaded from the write-back step of a sweep.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_WB))
        else $error("result appeared outside write-back");

    // An accepted tick starts its sweep at channel zero.
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_TICK) |=> (state_reg == ST_RD && cnt_reg == '0))
        else $error("tick sweep did not start at channel zero");

endmodule

// ===== rtl/cvf_ram.sv =====
// ----------------------------------------------------------------------------
// cvf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
